@@ rtl/pid_aw_pkg.sv @@
// Shared constants for the PID controller with integral clamp.
// Holds default widths, fraction positions, command codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package pid_aw_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int GAIN_WIDTH_DEF = 24;

    // fraction bits: integral holds IFRAC more than the data, gains OFRAC
    localparam int IFRAC = 8;
    localparam int OFRAC = 16;

    localparam int CMD_W = 1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KI_DT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KD_DT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WINDUP = 3'd5;

endpackage

@@ rtl/pid_aw_in_if.sv @@
// Input channel of the PID controller: one error sample or clear command per beat.
// Depends on pid_aw_pkg.
`timescale 1ns / 1ps

interface pid_aw_in_if #(
    parameter int DATA_WIDTH = pid_aw_pkg::DATA_WIDTH_DEF
);
    import pid_aw_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             cmd;
    logic signed [DATA_WIDTH-1:0] error_in;

    modport source (output valid, output cmd, output error_in, input ready);
    modport sink   (input valid, input cmd, input error_in, output ready);
endinterface

@@ rtl/pid_aw_out_if.sv @@
// Output channel of the PID controller: drive value and integral per beat.
// Depends on pid_aw_pkg.
`timescale 1ns / 1ps

interface pid_aw_out_if #(
    parameter int DATA_WIDTH = pid_aw_pkg::DATA_WIDTH_DEF
);
    import pid_aw_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] control_out;
    logic signed [DATA_WIDTH-1:0] integral_term;

    modport source (output valid, output control_out, output integral_term, input ready);
    modport sink   (input valid, input control_out, input integral_term, output ready);
endinterface

@@ rtl/pid_antiwindup_controller_top.sv @@
// PID controller step with integral clamp (anti-windup) and output clamp.
// Depends on pid_aw_pkg, pid_aw_in_if and pid_aw_out_if.
`timescale 1ns / 1ps

// Each input beat carries a signed Q8.8 error sample (cmd step) or a clear
// command. A step adds ki_dt*error (floored to Q8.16) to the integral, clamps
// the integral to +/- windup_limit, then forms kp*e + integral + kd*(e - last e),
// floors it to Q8.8 and clamps it to [out_min, out_max]; when the limits
// are crossed out_max wins. A clear zeroes the integral and the last error
// and returns zero for both result fields. Each beat gives exactly one result
// beat. The datapath is three register stages (input capture, the three gain
// multipliers, integral update plus output sum and clamp); a result beat is
// registered in each in turn before it is offered. One beat is accepted every
// cycle while no stall backs up from the output. The integral add-and-clamp in
// the last stage and the last-error register in the first stage are the only
// loops; each feeds its own register back. Each stage moves on whenever the
// stage after it is empty or moving, so new beats still enter while a result
// waits at the output, until empty stages fill. Configuration is a plain write
// port (register index 0..5: kp_gain, ki_dt, kd_over_dt, out_min, out_max,
// windup_limit); writes take effect at once and are meant to be issued while
// the pipeline is empty. Writing ki_dt clears the integral; writing
// windup_limit caps the value at |out_max| and re-clamps the integral.
// Indexes beyond the list are ignored.
module pid_antiwindup_controller_top #(
    parameter int DATA_WIDTH = pid_aw_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_WIDTH = pid_aw_pkg::GAIN_WIDTH_DEF,
    localparam int CFG_W = (GAIN_WIDTH > DATA_WIDTH) ? GAIN_WIDTH : DATA_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pid_aw_pkg::REG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]                   i_cfg_data,
    pid_aw_in_if.sink                          i_in_ch,
    pid_aw_out_if.source                       o_out_ch
);
    import pid_aw_pkg::*;

    // datapath widths
    localparam int P_W   = GAIN_WIDTH + DATA_WIDTH + 1;        // gain * error
    localparam int DE_W  = DATA_WIDTH + 1;                     // error difference
    localparam int D_W   = GAIN_WIDTH + DE_W + 1;              // gain * difference
    localparam int INC_W = P_W - IFRAC;                        // integral increment
    localparam int ACC_W = DATA_WIDTH + IFRAC;                 // integral, Q.16
    localparam int INT_W = ((ACC_W > INC_W) ? ACC_W : INC_W) + 1;
    localparam int SH_W  = ACC_W + IFRAC;                      // integral at Q.24
    localparam int SUM_W = ((D_W > SH_W) ? D_W : SH_W) + 2;
    localparam int Y_W   = SUM_W - OFRAC;
    localparam int WL_W  = DATA_WIDTH - 1;

    // configuration registers
    logic [GAIN_WIDTH-1:0]        r_kp;
    logic [GAIN_WIDTH-1:0]        r_ki;
    logic [GAIN_WIDTH-1:0]        r_kd;
    logic signed [DATA_WIDTH-1:0] r_min;
    logic signed [DATA_WIDTH-1:0] r_max;
    logic [WL_W-1:0]              r_windup;

    // controller state
    logic signed [ACC_W-1:0]      r_integral;
    logic signed [DATA_WIDTH-1:0] r_last_err;

    // stage 1: captured beat
    logic                         r_v1;
    logic [CMD_W-1:0]             r_cmd1;
    logic signed [DATA_WIDTH-1:0] r_e1;
    logic signed [DE_W-1:0]       r_de1;

    // stage 2: products
    logic                         r_v2;
    logic [CMD_W-1:0]             r_cmd2;
    logic signed [P_W-1:0]        r_p2;
    logic signed [P_W-1:0]        r_i2;
    logic signed [D_W-1:0]        r_d2;

    // stage 3: result register
    logic                         r_v3;
    logic signed [DATA_WIDTH-1:0] r_ctl;
    logic signed [DATA_WIDTH-1:0] r_iterm;

    logic en1, en2, en3;
    logic acc_in, step3;

    logic signed [DE_W-1:0]       n_de;
    logic signed [P_W-1:0]        n_p;
    logic signed [P_W-1:0]        n_i;
    logic signed [D_W-1:0]        n_d;

    logic signed [INC_W-1:0]      w_inc;
    logic signed [INT_W-1:0]      w_lim;
    logic signed [INT_W-1:0]      w_int_raw;
    logic signed [ACC_W-1:0]      n_integral;
    logic signed [SH_W-1:0]       w_int_sh;
    logic signed [SUM_W-1:0]      w_sum;
    logic signed [Y_W-1:0]        w_y;
    logic signed [Y_W-1:0]        w_lo;
    logic signed [Y_W-1:0]        w_hi;
    logic signed [Y_W-1:0]        w_y_cl;
    logic signed [DATA_WIDTH-1:0] n_ctl;
    logic signed [DATA_WIDTH-1:0] n_iterm;

    logic                         cfg_ki_wr;
    logic                         cfg_wl_wr;
    logic [DATA_WIDTH-1:0]        w_cap;
    logic [WL_W-1:0]              w_wl_req;
    logic [WL_W-1:0]              n_windup;
    logic signed [INT_W-1:0]      w_wl_lim;
    logic signed [ACC_W-1:0]      w_int_reclamp;
    logic signed [ACC_W-1:0]      w_lim_acc;

    function automatic logic signed [INT_W-1:0] f_clamp(
        input logic signed [INT_W-1:0] v,
        input logic signed [INT_W-1:0] lim
    );
        logic signed [INT_W-1:0] res;
        res = v;
        if (res < -lim) begin
            res = -lim;
        end
        if (res > lim) begin
            res = lim;
        end
        return res;
    endfunction

    // each stage advances when the next one is empty or advancing
    assign en3 = !r_v3 || o_out_ch.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_in_ch.ready = en1;
    assign acc_in = i_in_ch.valid && en1;
    assign step3  = r_v2 && en3;

    assign o_out_ch.valid         = r_v3;
    assign o_out_ch.control_out   = r_ctl;
    assign o_out_ch.integral_term = r_iterm;

    // stage 1: difference against the last accepted error
    assign n_de = DE_W'(i_in_ch.error_in) - DE_W'(r_last_err);

    // stage 2: the three gain products
    assign n_p = $signed({1'b0, r_kp}) * r_e1;
    assign n_i = $signed({1'b0, r_ki}) * r_e1;
    assign n_d = $signed({1'b0, r_kd}) * r_de1;

    // stage 3: integral update, sum, floor and clamp
    assign w_inc      = r_i2[P_W-1:IFRAC];
    assign w_lim      = INT_W'($signed({1'b0, r_windup, {IFRAC{1'b0}}}));
    assign w_lim_acc  = ACC_W'($signed({1'b0, r_windup, {IFRAC{1'b0}}}));
    assign w_int_raw  = INT_W'(r_integral) + INT_W'(w_inc);
    assign n_integral = ACC_W'(f_clamp(w_int_raw, w_lim));
    assign w_int_sh   = $signed({n_integral, {IFRAC{1'b0}}});
    assign w_sum      = SUM_W'(r_p2) + SUM_W'(r_d2) + SUM_W'(w_int_sh);
    assign w_y        = w_sum[SUM_W-1:OFRAC];
    assign w_lo       = Y_W'(r_min);
    assign w_hi       = Y_W'(r_max);

    always_comb begin
        w_y_cl = w_y;
        if (w_y_cl < w_lo) begin
            w_y_cl = w_lo;
        end
        if (w_y_cl > w_hi) begin
            w_y_cl = w_hi;
        end
    end

    always_comb begin
        if (r_cmd2 == CMD_CLEAR) begin
            n_ctl   = '0;
            n_iterm = '0;
        end else begin
            n_ctl   = w_y_cl[DATA_WIDTH-1:0];
            n_iterm = n_integral[ACC_W-1:IFRAC];
        end
    end

    // windup write: cap at |out_max|, then re-clamp the integral
    assign cfg_ki_wr = i_cfg_we && (i_cfg_idx == REG_KI_DT);
    assign cfg_wl_wr = i_cfg_we && (i_cfg_idx == REG_WINDUP);
    assign w_cap     = r_max[DATA_WIDTH-1] ? DATA_WIDTH'(-r_max) : DATA_WIDTH'(r_max);
    assign w_wl_req  = i_cfg_data[WL_W-1:0];
    assign n_windup  = ({1'b0, w_wl_req} > w_cap) ? w_cap[WL_W-1:0] : w_wl_req;
    assign w_wl_lim  = INT_W'($signed({1'b0, n_windup, {IFRAC{1'b0}}}));
    assign w_int_reclamp = ACC_W'(f_clamp(INT_W'(r_integral), w_wl_lim));

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_last_err <= '0;
            r_integral <= '0;
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_min      <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            r_max      <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
            r_windup   <= '1;
        end else begin
            if (en1) begin
                r_v1 <= i_in_ch.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (acc_in) begin
                r_last_err <= (i_in_ch.cmd == CMD_CLEAR) ? '0 : i_in_ch.error_in;
            end

            // a ki_dt or windup_limit write overrides a step on the integral
            if (cfg_ki_wr) begin
                r_integral <= '0;
            end else if (cfg_wl_wr) begin
                r_integral <= w_int_reclamp;
            end else if (step3) begin
                r_integral <= (r_cmd2 == CMD_CLEAR) ? '0 : n_integral;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KP:     r_kp     <= i_cfg_data[GAIN_WIDTH-1:0];
                    REG_KI_DT:  r_ki     <= i_cfg_data[GAIN_WIDTH-1:0];
                    REG_KD_DT:  r_kd     <= i_cfg_data[GAIN_WIDTH-1:0];
                    REG_MIN:    r_min    <= i_cfg_data[DATA_WIDTH-1:0];
                    REG_MAX:    r_max    <= i_cfg_data[DATA_WIDTH-1:0];
                    REG_WINDUP: r_windup <= n_windup;
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_cmd1 <= i_in_ch.cmd;
            r_e1   <= i_in_ch.error_in;
            r_de1  <= n_de;
        end
        if (en2 && r_v1) begin
            r_cmd2 <= r_cmd1;
            r_p2   <= n_p;
            r_i2   <= n_i;
            r_d2   <= n_d;
        end
        if (step3) begin
            r_ctl   <= n_ctl;
            r_iterm <= n_iterm;
        end
    end

`ifndef SYNTHESIS
    a_integral_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integral <= w_lim_acc) && (r_integral >= -w_lim_acc))
        else $error("integral outside windup limit");

    a_windup_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wl_wr |=> ({1'b0, r_windup} <= w_cap))
        else $error("windup limit above |out_max| after write");

    a_ki_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_ki_wr |=> (r_integral == '0))
        else $error("ki_dt write did not clear integral");

    a_clear_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step3 && (r_cmd2 == CMD_CLEAR))
            |=> (r_v3 && (r_ctl == '0) && (r_iterm == '0)))
        else $error("clear beat gave nonzero result");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en3) |=> (r_v2 && r_v3))
        else $error("stage 2 beat lost under stall");
`endif

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for pid_antiwindup_controller_top: PID steps with integral clamp.
// A scoreboard class predicts each step's drive and integral and checks the output beats.
// Depends on pid_aw_pkg, pid_aw_in_if, pid_aw_out_if and the controller RTL.
`timescale 1ns / 1ps

module tb_top;
    import pid_aw_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int GW = GAIN_WIDTH_DEF;
    localparam int CW = (GW > DW) ? GW : DW;

    // indexes past the register list; writes there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int DRAIN_CYCLES    = 6;     // pipeline is three stages deep
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic signed [DW-1:0] integ;
    } pid_result_t;

    // Mirrors the gains, clamps and loop state, and holds the drive/integral
    // pairs that the controller still owes, oldest first.
    class pid_loop_scoreboard;
        logic [GW-1:0] kp_gain;
        logic [GW-1:0] ki_dt;
        logic [GW-1:0] kd_over_dt;
        longint        out_lo;
        longint        out_hi;
        longint        windup_lim;
        longint        integ_q16;
        longint        prev_err;
        pid_result_t   expected_q[$];
        int            beats_seen;
        int            mismatches;

        function new();
            kp_gain    = '0;
            ki_dt      = '0;
            kd_over_dt = '0;
            out_lo     = -(longint'(1) <<< (DW - 1));
            out_hi     = (longint'(1) <<< (DW - 1)) - 1;
            windup_lim = out_hi;
            integ_q16  = 0;
            prev_err   = 0;
            beats_seen = 0;
            mismatches = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            // raise to lo first, then cap at hi: hi wins when they cross
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            return v;
        endfunction

        function void apply_write(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] data);
            longint lim;
            longint cap;
            case (idx)
                REG_KP:    kp_gain = data[GW-1:0];
                REG_KI_DT: begin
                    ki_dt     = data[GW-1:0];
                    integ_q16 = 0;
                end
                REG_KD_DT: kd_over_dt = data[GW-1:0];
                REG_MIN:   out_lo = longint'($signed(data[DW-1:0]));
                REG_MAX:   out_hi = longint'($signed(data[DW-1:0]));
                REG_WINDUP: begin
                    lim        = longint'(data[DW-2:0]);
                    cap        = (out_hi < 0) ? -out_hi : out_hi;
                    windup_lim = (lim > cap) ? cap : lim;
                    integ_q16  = clip(integ_q16, -(windup_lim <<< IFRAC), windup_lim <<< IFRAC);
                end
                default: ;
            endcase
        endfunction

        // Predict one accepted input beat.
        function void take_sample(logic [CMD_W-1:0] cmd, logic signed [DW-1:0] err);
            longint      e;
            longint      sum;
            pid_result_t r;
            if (cmd == CMD_CLEAR) begin
                integ_q16 = 0;
                prev_err  = 0;
                r         = '0;
            end else begin
                e         = err;
                integ_q16 = integ_q16 + ((longint'(ki_dt) * e) >>> IFRAC);
                integ_q16 = clip(integ_q16, -(windup_lim <<< IFRAC), windup_lim <<< IFRAC);
                sum = longint'(kp_gain) * e + (integ_q16 <<< IFRAC)
                    + longint'(kd_over_dt) * (e - prev_err);
                prev_err = e;
                r.drive  = DW'(clip(sum >>> OFRAC, out_lo, out_hi));
                r.integ  = DW'(integ_q16 >>> IFRAC);
            end
            expected_q.push_back(r);
        endfunction

        // Compare one accepted output beat with the oldest prediction.
        function void check_drive(logic signed [DW-1:0] drive, logic signed [DW-1:0] integ);
            pid_result_t want;
            beats_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] beat %0d unexpected: control_out %0d integral_term %0d",
                             $time, beats_seen, drive, integ);
                return;
            end
            want = expected_q.pop_front();
            if (drive !== want.drive || integ !== want.integ) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] beat %0d: control_out exp %0d got %0d, integral_term exp %0d got %0d",
                             $time, beats_seen, want.drive, drive, want.integ, integ);
            end
        endfunction

        function bit failed();
            return (mismatches != 0) || (expected_q.size() != 0);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_idx;
    logic [CW-1:0]        i_cfg_data;

    pid_aw_in_if  #(.DATA_WIDTH(DW)) in_ch ();
    pid_aw_out_if #(.DATA_WIDTH(DW)) out_ch ();

    pid_antiwindup_controller_top #(
        .DATA_WIDTH(DW),
        .GAIN_WIDTH(GW)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    pid_loop_scoreboard board = new();

    bit                   gap_on;
    bit                   stall_on;
    logic signed [DW-1:0] walk_err;
    int                   cycle_count = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("** pid_antiwindup_controller_top: FAILED **");
        $finish;
    end

    // Monitor: mirror register writes, predict accepted inputs, check results.
    // Everything is sampled at the rising edge; the drivers only move on the
    // falling edge, so the values seen here are stable.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                board.apply_write(i_cfg_idx, i_cfg_data);
            if (in_ch.valid && in_ch.ready)
                board.take_sample(in_ch.cmd, in_ch.error_in);
            if (out_ch.valid && out_ch.ready)
                board.check_drive(out_ch.control_out, out_ch.integral_term);
        end
    end

    // Result side back-pressure: drop ready at random while stall_on is set.
    initial begin : out_stall_gen
        int hold;
        hold         = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                out_ch.ready = 1'b0;
                hold--;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready = 1'b0;
                hold         = $urandom_range(0, 4);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Present one beat, with an optional gap first; return on the falling
    // edge after it was taken, valid still high.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic signed [DW-1:0] err);
        if (gap_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.cmd      = cmd;
        in_ch.error_in = err;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold the input side until every predicted beat has come back, then
    // let the pipeline settle so the block is idle for register writes.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CW-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we = 1'b0;
    endtask

    // Place a narrow register value in the low bits with junk above it.
    function automatic logic [CW-1:0] with_junk(input logic [DW-1:0] v);
        logic [CW-1:0] d;
        d          = CW'($urandom);
        d[DW-1:0]  = v;
        return d;
    endfunction

    function automatic logic [GW-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return GW'($urandom);
            1:       return GW'($urandom_range(0, 32'h3_FFFF));
            2:       return ($urandom_range(0, 1) != 0) ? {GW{1'b1}} : {GW{1'b0}};
            default: return GW'($urandom_range(0, 32'hFFFF));
        endcase
    endfunction

    function automatic logic signed [DW-1:0] pick_corner();
        case ($urandom_range(0, 4))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    task automatic config_random();
        logic signed [DW-1:0] lo;
        logic signed [DW-1:0] hi;
        logic [DW-2:0]        wl;
        case ($urandom_range(0, 3))
            0: begin
                // fully random, limits may cross
                lo = DW'($urandom);
                hi = DW'($urandom);
            end
            3: begin
                lo = 16'sh8000;
                hi = 16'sh7FFF;
            end
            default: begin
                hi = DW'($urandom_range(0, 32767));
                lo = DW'(0 - int'($urandom_range(0, 32768)));
            end
        endcase
        case ($urandom_range(0, 2))
            0:       wl = (DW-1)'($urandom);
            1:       wl = (DW-1)'($urandom_range(0, 16'h0400));
            default: wl = '1;
        endcase
        write_reg(REG_KP, pick_gain());
        write_reg(REG_KI_DT, pick_gain());
        write_reg(REG_KD_DT, pick_gain());
        write_reg(REG_MIN, with_junk(lo));
        write_reg(REG_MAX, with_junk(hi));
        write_reg(REG_WINDUP, with_junk({1'($urandom), wl}));
        // move max after the windup cap now and then: the cap must not follow
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_MAX, with_junk(DW'($urandom)));
        if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, CW'($urandom));
        cfg_done();
    endtask

    // Mostly a slowly wandering error, as a closed loop would produce, with
    // corners, full-range jumps and an occasional clear mixed in.
    task automatic send_random(input int n);
        longint t;
        repeat (n) begin
            case ($urandom_range(0, 15))
                0:       send_beat(CMD_CLEAR, DW'($urandom));
                1:       send_beat(CMD_STEP, pick_corner());
                2, 3, 4: send_beat(CMD_STEP, DW'($urandom));
                default: begin
                    t = longint'(walk_err) + longint'($urandom_range(0, 128)) - 64;
                    if (t > 32767) t = 32767;
                    if (t < -32768) t = -32768;
                    walk_err = DW'(t);
                    send_beat(CMD_STEP, walk_err);
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.cmd      = CMD_STEP;
        in_ch.error_in = '0;
        walk_err       = '0;
        gap_on         = 1'b1;
        stall_on       = 1'b1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset gains are zero: a full-scale step must give zero drive.
        send_beat(CMD_STEP, 16'sh7FFF);
        send_beat(CMD_CLEAR, 16'sh8000);
        drain();

        // Unit P, moderate I and D, symmetric clamps; windup asks for more
        // than |out_max| and gets capped. Spare indexes must be ignored.
        write_reg(REG_KP, 24'h01_0000);
        write_reg(REG_KI_DT, 24'h00_8000);
        write_reg(REG_KD_DT, 24'h00_4000);
        write_reg(REG_MIN, 24'h00_D000);
        write_reg(REG_MAX, 24'h00_3000);
        write_reg(REG_WINDUP, 24'hFF_7FFF);
        write_reg(REG_SPARE_LO, 24'hFF_FFFF);
        write_reg(REG_SPARE_HI, 24'h00_0000);
        cfg_done();
        send_beat(CMD_STEP, 16'sh7FFF);
        send_beat(CMD_STEP, 16'sh7FFF);
        send_beat(CMD_STEP, 16'sh7FFF);
        send_beat(CMD_STEP, 16'sh8000);
        send_beat(CMD_STEP, 16'sh8000);
        send_beat(CMD_STEP, 16'sh0000);
        send_beat(CMD_STEP, 16'sd1);
        send_beat(CMD_STEP, -16'sd1);
        send_beat(CMD_CLEAR, 16'sh5A5A);     // error ignored on clear
        send_beat(CMD_STEP, 16'sh0100);
        drain();

        // Full-scale gains with crossed limits: out_max must win.
        // Windup against max = -32768 caps at 32768, i.e. no cap at all.
        write_reg(REG_KP, 24'hFF_FFFF);
        write_reg(REG_KI_DT, 24'hFF_FFFF);
        write_reg(REG_KD_DT, 24'hFF_FFFF);
        write_reg(REG_MAX, 24'h00_8000);
        write_reg(REG_WINDUP, 24'h00_7FFF);
        write_reg(REG_MIN, 24'h00_7FFF);
        cfg_done();
        send_beat(CMD_STEP, 16'sh7FFF);
        send_beat(CMD_STEP, 16'sh8000);
        send_beat(CMD_STEP, 16'sh8000);
        send_beat(CMD_STEP, 16'sh0000);
        send_beat(CMD_CLEAR, 16'sh7FFF);
        drain();

        // Pure integrator. Windup capped at 0x1000, then max lowered: the
        // integral keeps its 0x1000 bound while the drive stops at 0x100.
        write_reg(REG_KP, 24'h00_0000);
        write_reg(REG_KD_DT, 24'h00_0000);
        write_reg(REG_KI_DT, 24'h02_0000);
        write_reg(REG_MIN, 24'h00_8000);
        write_reg(REG_MAX, 24'h00_1000);
        write_reg(REG_WINDUP, 24'h00_FFFF);
        write_reg(REG_MAX, 24'h00_0100);
        cfg_done();
        send_beat(CMD_STEP, 16'sh7FFF);
        send_beat(CMD_STEP, 16'sh7FFF);
        send_beat(CMD_STEP, 16'sh8001);
        send_beat(CMD_STEP, 16'sh7FFF);
        drain();
        // lower windup below the held integral: it must be pulled in
        write_reg(REG_WINDUP, 24'h00_0080);
        cfg_done();
        send_beat(CMD_STEP, 16'sh0000);
        drain();
        // rewriting ki_dt clears the integral
        write_reg(REG_KI_DT, 24'h02_0000);
        cfg_done();
        send_beat(CMD_STEP, 16'sh0000);
        drain();

        // Random phases, each under fresh settings; the last runs flat out.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES - 1) begin
                gap_on   = 1'b0;
                stall_on = 1'b0;
            end
            config_random();
            send_random(ITEMS_PER_PHASE);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.failed())
            $display("** pid_antiwindup_controller_top: FAILED **");
        else
            $display("** pid_antiwindup_controller_top: PASSED **");
        $finish;
    end

endmodule

@@ pid_antiwindup_controller_top.f @@
rtl/pid_aw_pkg.sv
rtl/pid_aw_in_if.sv
rtl/pid_aw_out_if.sv
rtl/pid_antiwindup_controller_top.sv
test/tb_top.sv
